@@ sv/sha1md_pkg.sv @@
// Shared types, constants and state encodings of the SHA-1 message digest block.
package sha1md_pkg;

  typedef logic [31:0] word_t;

  localparam int unsigned BlockWords = 16;
  localparam int unsigned ChainWords = 5;
  localparam int unsigned CountW     = 61;
  localparam int unsigned RoundW     = 7;

  localparam logic [RoundW-1:0] LastRound   = 7'd79;
  localparam logic [RoundW-1:0] PhaseTwo    = 7'd20;
  localparam logic [RoundW-1:0] PhaseThree  = 7'd40;
  localparam logic [RoundW-1:0] PhaseFour   = 7'd60;

  // Initial chaining words; index 0 is the first digest word.
  localparam word_t [ChainWords-1:0] InitChain = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam word_t RoundK0 = 32'h5A827999;
  localparam word_t RoundK1 = 32'h6ED9EBA1;
  localparam word_t RoundK2 = 32'h8F1BBCDC;
  localparam word_t RoundK3 = 32'hCA62C1D6;

  localparam logic [7:0] PadByte = 8'h80;

  // One 512-bit block on its way from the packer to the round engine.
  typedef struct packed {
    logic                     last;
    word_t [BlockWords-1:0]   words;
  } blk_t;

  typedef enum logic [1:0] {
    FE_RUN,
    FE_PAD,
    FE_LEN
  } fe_state_e;

  typedef enum logic [1:0] {
    CO_IDLE,
    CO_ROUND,
    CO_ADD
  } co_state_e;

endpackage

@@ sv/sha1md_front.sv @@
// Byte packer and padding generator of the SHA-1 block: builds 512-bit blocks.
module sha1md_front import sha1md_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] data_byte_i,
  input  logic       has_byte_i,
  input  logic       end_of_message_i,
  output blk_t       blk_o,
  output logic       blk_push_o,
  input  logic       blk_full_i
);

  fe_state_e               state_q, state_d;
  logic [CountW-1:0]       count_q, count_d;
  word_t [BlockWords-1:0]  buf_q, buf_d;

  logic [5:0]              pos;
  logic [3:0]              wi;
  logic [1:0]              bsel;
  logic [4:0]              shift;
  logic [CountW-1:0]       count_inc;
  word_t [BlockWords-1:0]  buf_wr;
  word_t [BlockWords-1:0]  pad_words;
  word_t                   keep_mask;
  logic [63:0]             len_bits;
  logic                    pad_fits;
  logic                    accept;

  assign pos       = count_q[5:0];
  assign wi        = pos[5:2];
  assign bsel      = pos[1:0];
  assign shift     = {~bsel, 3'b000};
  assign count_inc = count_q + CountW'(1);
  assign len_bits  = {count_q, 3'b000};
  assign pad_fits  = (pos[5:3] != 3'b111);
  assign keep_mask = ~(32'hFFFF_FFFF >> {bsel, 3'b000});
  assign full      = (state_q != FE_RUN) || blk_full_i;
  assign accept    = push && !full;

  // The first byte of a word overwrites it, later bytes are merged in.
  always_comb begin
    buf_wr = buf_q;
    if (bsel == 2'd0) begin
      buf_wr[wi] = {data_byte_i, 24'h0};
    end else begin
      buf_wr[wi] = buf_q[wi] | (word_t'(data_byte_i) << shift);
    end
  end

  // Closing block: bytes so far, the pad marker, then zeros.
  always_comb begin
    for (int i = 0; i < BlockWords; i++) begin
      if (4'(i) < wi) begin
        pad_words[i] = buf_q[i];
      end else if (4'(i) == wi) begin
        pad_words[i] = (buf_q[i] & keep_mask) | (word_t'(PadByte) << shift);
      end else begin
        pad_words[i] = '0;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    buf_d       = buf_q;
    blk_push_o  = 1'b0;
    blk_o.last  = 1'b0;
    blk_o.words = buf_wr;
    unique case (state_q)
      FE_RUN: begin
        if (accept) begin
          if (has_byte_i) begin
            buf_d   = buf_wr;
            count_d = count_inc;
            if (count_inc[5:0] == 6'd0) begin
              blk_push_o = 1'b1;
            end
          end
          if (end_of_message_i) begin
            state_d = FE_PAD;
          end
        end
      end
      FE_PAD: begin
        blk_o.words = pad_words;
        if (!blk_full_i) begin
          blk_push_o = 1'b1;
          if (pad_fits) begin
            blk_o.words[14] = len_bits[63:32];
            blk_o.words[15] = len_bits[31:0];
            blk_o.last      = 1'b1;
            count_d         = '0;
            state_d         = FE_RUN;
          end else begin
            state_d = FE_LEN;
          end
        end
      end
      FE_LEN: begin
        blk_o.words     = '0;
        blk_o.words[14] = len_bits[63:32];
        blk_o.words[15] = len_bits[31:0];
        blk_o.last      = 1'b1;
        if (!blk_full_i) begin
          blk_push_o = 1'b1;
          count_d    = '0;
          state_d    = FE_RUN;
        end
      end
      default: begin
        state_d = FE_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FE_RUN;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

endmodule

@@ sv/sha1md_blkq.sv @@
// Short block queue that decouples the byte packer from the round engine.
module sha1md_blkq import sha1md_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  blk_t data_i,
  output logic full_o,
  input  logic pop_i,
  output blk_t data_o,
  output logic empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  blk_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ sv/sha1md_core.sv @@
// SHA-1 round engine: 80 rounds per block, chaining update and digest holding register.
module sha1md_core import sha1md_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  blk_t                    blk_i,
  input  logic                    blk_empty_i,
  output logic                    blk_pop_o,
  output word_t [ChainWords-1:0]  digest_o,
  output logic                    empty,
  input  logic                    pop
);

  co_state_e               state_q, state_d;
  logic [RoundW-1:0]       rnd_q, rnd_d;
  word_t [ChainWords-1:0]  work_q, work_d;
  word_t [BlockWords-1:0]  w_q, w_d;
  word_t [ChainWords-1:0]  chain_q, chain_d;
  word_t [ChainWords-1:0]  out_q, out_d;
  logic                    last_q, last_d;
  logic                    out_valid_q, out_valid_d;

  word_t                   wa, wb, wc, wd, we;
  word_t                   wt, wx, f, k, t;
  word_t [ChainWords-1:0]  sum;
  logic                    out_free;

  assign wa = work_q[0];
  assign wb = work_q[1];
  assign wc = work_q[2];
  assign wd = work_q[3];
  assign we = work_q[4];

  // 16-word message schedule shift line; w_q[0] is the current word in the early rounds.
  assign wx = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
  assign wt = (rnd_q[6:4] == 3'd0) ? w_q[0] : {wx[30:0], wx[31]};

  always_comb begin
    if (rnd_q < PhaseTwo) begin
      f = (wb & wc) | (~wb & wd);
      k = RoundK0;
    end else if (rnd_q < PhaseThree) begin
      f = wb ^ wc ^ wd;
      k = RoundK1;
    end else if (rnd_q < PhaseFour) begin
      f = (wb & wc) | (wb & wd) | (wc & wd);
      k = RoundK2;
    end else begin
      f = wb ^ wc ^ wd;
      k = RoundK3;
    end
  end

  assign t = {wa[26:0], wa[31:27]} + f + we + k + wt;

  always_comb begin
    for (int i = 0; i < ChainWords; i++) begin
      sum[i] = chain_q[i] + work_q[i];
    end
  end

  assign out_free = !out_valid_q || pop;
  assign empty    = !out_valid_q;
  assign digest_o = out_q;

  always_comb begin
    state_d     = state_q;
    rnd_d       = rnd_q;
    work_d      = work_q;
    w_d         = w_q;
    chain_d     = chain_q;
    out_d       = out_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !pop;
    blk_pop_o   = 1'b0;
    unique case (state_q)
      CO_IDLE: begin
        if (!blk_empty_i) begin
          blk_pop_o = 1'b1;
          work_d    = chain_q;
          w_d       = blk_i.words;
          last_d    = blk_i.last;
          rnd_d     = '0;
          state_d   = CO_ROUND;
        end
      end
      CO_ROUND: begin
        work_d[0] = t;
        work_d[1] = wa;
        work_d[2] = {wb[1:0], wb[31:2]};
        work_d[3] = wc;
        work_d[4] = wd;
        for (int i = 0; i < BlockWords - 1; i++) begin
          w_d[i] = w_q[i+1];
        end
        w_d[BlockWords-1] = wt;
        rnd_d = rnd_q + RoundW'(1);
        if (rnd_q == LastRound) begin
          state_d = CO_ADD;
        end
      end
      CO_ADD: begin
        if (!last_q) begin
          chain_d = sum;
          state_d = CO_IDLE;
        end else if (out_free) begin
          out_d       = sum;
          out_valid_d = 1'b1;
          chain_d     = InitChain;
          state_d     = CO_IDLE;
        end
      end
      default: begin
        state_d = CO_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CO_IDLE;
      rnd_q       <= '0;
      chain_q     <= InitChain;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rnd_q       <= rnd_d;
      chain_q     <= chain_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    w_q    <= w_d;
    out_q  <= out_d;
  end

endmodule

@@ sv/sha1_message_digest.sv @@
// Top level of the SHA-1 message digest block: packer, block queue and round engine.
//
// The block hashes a byte stream with SHA-1 and returns one 160-bit digest per
// message. Each input beat may carry one message byte (has_byte_i) and may close
// the message (end_of_message_i); a beat with neither flag does nothing, and a
// closing beat without a byte ends the message before it. The packer takes one
// beat per cycle while full is low and hands each full 64-byte block to a short
// block queue; the round engine takes blocks from that queue and works through
// each as a load, 80 rounds at one round per cycle and a chaining add. Its single
// round adder therefore sets the sustained rate for long messages, with full held
// high while the queue is full. After the closing beat, full stays high while the
// packer queues one or two padding blocks. The digest appears once the round
// engine has hashed the last padding block; blocks still queued ahead of the
// padding delay it, and so does a full holding register. The digest sits in a
// holding register until popped; the packer keeps accepting the next message
// meanwhile, and only the final chaining add of a later message waits for that
// register to be free. The byte count wraps modulo 2^61 as in the standard length
// field. BlkQueueDepth sets how many finished blocks may wait between the packer
// and the round engine.
module sha1_message_digest import sha1md_pkg::*; #(
  parameter int unsigned BlkQueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        end_of_message_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] digest_word0_o,
  output logic [31:0] digest_word1_o,
  output logic [31:0] digest_word2_o,
  output logic [31:0] digest_word3_o,
  output logic [31:0] digest_word4_o
);

  blk_t                    fe_blk;
  logic                    blk_push;
  logic                    blk_full;
  blk_t                    q_blk;
  logic                    blk_pop;
  logic                    blk_empty;
  word_t [ChainWords-1:0]  digest;

  sha1md_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .data_byte_i      (data_byte_i),
    .has_byte_i       (has_byte_i),
    .end_of_message_i (end_of_message_i),
    .blk_o            (fe_blk),
    .blk_push_o       (blk_push),
    .blk_full_i       (blk_full)
  );

  sha1md_blkq #(
    .Depth (BlkQueueDepth)
  ) u_blkq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (blk_push),
    .data_i  (fe_blk),
    .full_o  (blk_full),
    .pop_i   (blk_pop),
    .data_o  (q_blk),
    .empty_o (blk_empty)
  );

  sha1md_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .blk_i       (q_blk),
    .blk_empty_i (blk_empty),
    .blk_pop_o   (blk_pop),
    .digest_o    (digest),
    .empty       (empty),
    .pop         (pop)
  );

  assign digest_word0_o = digest[0];
  assign digest_word1_o = digest[1];
  assign digest_word2_o = digest[2];
  assign digest_word3_o = digest[3];
  assign digest_word4_o = digest[4];

  // The packer only hands over a block when the queue has room for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni) blk_push |-> !blk_full)
    else $error("block pushed into a full block queue");

  // The round engine only takes a block that is actually waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni) blk_pop |-> !blk_empty)
    else $error("block popped from an empty block queue");

  // A closing beat always leads into padding, so the input side must back off.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !full && end_of_message_i) |=> full)
    else $error("input accepted during padding of a closed message");

endmodule
